// File: rtl/tls_sni_pkg.sv
`default_nettype none
package tls_sni_pkg;

  typedef enum logic [4:0] {
    PH_HEAD = 5'd0,
    PH_SID  = 5'd1,
    PH_CSHI = 5'd2,
    PH_CSLO = 5'd3,
    PH_COMP = 5'd4,
    PH_EXHI = 5'd5,
    PH_EXLO = 5'd6,
    PH_ET0  = 5'd7,
    PH_ET1  = 5'd8,
    PH_EL0  = 5'd9,
    PH_EL1  = 5'd10,
    PH_SNI  = 5'd11,
    PH_ALPN = 5'd12,
    PH_SV   = 5'd13,
    PH_SKIP = 5'd14,
    PH_IDLE = 5'd15
  } phase_t;

  localparam logic [1:0]  KIND_SNI     = 2'd0;
  localparam logic [1:0]  KIND_ALPN    = 2'd1;
  localparam logic [1:0]  KIND_SUMMARY = 2'd2;

  localparam logic [7:0]  REC_HANDSHAKE = 8'd22;
  localparam logic [7:0]  REC_ALERT     = 8'd21;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [16:0] HELLO_MIN     = 17'd43;
  localparam logic [15:0] EXT_SNI       = 16'h0000;
  localparam logic [15:0] EXT_ALPN      = 16'h0010;
  localparam logic [15:0] EXT_VERSIONS  = 16'h002B;
  localparam logic [15:0] VER_TLS13     = 16'h0304;
  localparam logic [8:0]  ABSENT        = 9'd256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [7:0]  content_type;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [15:0] record_length;
    logic [8:0]  handshake_kind;
    logic [8:0]  alert_sev;
    logic [8:0]  alert_reason;
    logic [2:0]  version_label;
    logic        header_valid;
    logic        run_end;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/tls_client_hello_sni_alpn_parser.sv
`default_nettype none
// Parses one TLS record per run, one byte per word, at up to one word per
// clock. Each accepted byte updates the parse state in the same cycle and may
// yield an SNI or ALPN character; the byte flagged tlast also yields a summary
// word (tlast set on the output). Results go through a four-word output queue;
// s_tready drops while fewer than two slots are free, so the sustained rate is
// one byte per cycle as long as the output side drains one word per cycle.
module tls_client_hello_sni_alpn_parser
  import tls_sni_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // data_byte[7:0], total_length[23:8]
  input  wire         s_tuser,   // first_byte
  input  wire         s_tlast,   // last_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [79:0] m_tdata,   // name_byte, content type, major version,
                                 // minor version, record_length[15:0],
                                 // handshake_kind[8:0], alert level[8:0],
                                 // alert_reason[8:0], version_label[2:0],
                                 // header_valid, zero pad
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast    // run_end
);

  logic [15:0] offset, offset_next;
  logic [15:0] rbytes, rbytes_next;
  phase_t      phase, phase_next;
  logic [16:0] field_end, field_end_next;
  logic [16:0] ext_end, ext_end_next;
  logic [15:0] ext_id, ext_id_next;
  logic [15:0] ext_len, ext_len_next;
  logic [15:0] inner, inner_next;
  logic [7:0]  hdr [7];
  logic [7:0]  hdr_next [7];
  logic        tls13, tls13_next;

  result_t     res_name, res_sum;
  logic        name_vld;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] pos;
  logic [17:0] nxt;
  logic [17:0] start;
  logic        do_begin;
  logic [16:0] body_start;
  logic [16:0] r;
  logic [15:0] v16;
  logic [2:0]  label;

  assign accept = s_tvalid && s_tready;
  assign b      = s_tdata[7:0];

  always_comb begin
    offset_next    = offset;
    rbytes_next    = rbytes;
    phase_next     = phase;
    field_end_next = field_end;
    ext_end_next   = ext_end;
    ext_id_next    = ext_id;
    ext_len_next   = ext_len;
    inner_next     = inner;
    tls13_next     = tls13;
    for (int i = 0; i < 7; i++) hdr_next[i] = hdr[i];
    name_vld   = 1'b0;
    res_name   = '0;
    res_sum    = '0;
    nxt        = '0;
    start      = '0;
    do_begin   = 1'b0;
    body_start = '0;
    r          = '0;
    v16        = '0;
    label      = '0;
    pos        = offset;

    if (accept) begin
      if (s_tuser) begin
        offset_next    = '0;
        phase_next     = PH_HEAD;
        field_end_next = '0;
        ext_end_next   = '0;
        ext_id_next    = '0;
        ext_len_next   = '0;
        inner_next     = '0;
        tls13_next     = 1'b0;
        for (int i = 0; i < 7; i++) hdr_next[i] = '0;
        rbytes_next    = s_tdata[23:8];
        pos            = '0;
      end

      if (pos < rbytes_next) begin
        for (int i = 0; i < 7; i++) if (pos == 16'(i)) hdr_next[i] = b;
        if (phase_next == PH_HEAD) begin
          if (pos == 16'd5) begin
            if (hdr_next[0] == REC_HANDSHAKE && b == HS_CLIENT_HELLO &&
                {1'b0, rbytes_next} > HELLO_MIN) begin
              phase_next     = PH_SID;
              field_end_next = HELLO_MIN;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end else if (phase_next != PH_IDLE &&
                     !(phase_next <= PH_EL1 && {1'b0, pos} != field_end_next)) begin
          case (phase_next)
            PH_SID, PH_COMP: begin
              nxt = 18'(pos) + 18'd1 + 18'(b);
              if (nxt + 18'd2 > 18'(rbytes_next)) phase_next = PH_IDLE;
              else begin
                field_end_next = nxt[16:0];
                phase_next = (phase_next == PH_SID) ? PH_CSHI : PH_EXHI;
              end
            end
            PH_CSHI, PH_EXHI: begin
              inner_next     = 16'(b);
              field_end_next = 17'(pos) + 17'd1;
              phase_next     = (phase_next == PH_CSHI) ? PH_CSLO : PH_EXLO;
            end
            PH_CSLO: begin
              nxt = 18'(pos) + 18'd1 + 18'({inner_next[7:0], b});
              if (nxt >= 18'(rbytes_next)) phase_next = PH_IDLE;
              else begin
                field_end_next = nxt[16:0];
                phase_next = PH_COMP;
              end
            end
            PH_EXLO: begin
              nxt = 18'(pos) + 18'd1 + 18'({inner_next[7:0], b});
              ext_end_next = (nxt > 18'(rbytes_next)) ? 17'(rbytes_next) : nxt[16:0];
              start = 18'(pos) + 18'd1;
              do_begin = 1'b1;
            end
            PH_ET0: begin
              ext_id_next    = {b, 8'd0};
              field_end_next = 17'(pos) + 17'd1;
              phase_next     = PH_ET1;
            end
            PH_ET1: begin
              ext_id_next    = {ext_id_next[15:8], b};
              field_end_next = 17'(pos) + 17'd1;
              phase_next     = PH_EL0;
            end
            PH_EL0: begin
              ext_len_next   = {b, 8'd0};
              field_end_next = 17'(pos) + 17'd1;
              phase_next     = PH_EL1;
            end
            PH_EL1: begin
              ext_len_next = {ext_len_next[15:8], b};
              nxt = 18'(pos) + 18'd1;
              inner_next = '0;
              if (nxt + 18'(ext_len_next) > 18'(ext_end_next)) phase_next = PH_IDLE;
              else if (ext_len_next == 16'd0) begin
                start = nxt;
                do_begin = 1'b1;
              end else begin
                field_end_next = 17'(nxt + 18'(ext_len_next));
                if (ext_id_next == EXT_SNI)           phase_next = PH_SNI;
                else if (ext_id_next == EXT_ALPN)     phase_next = PH_ALPN;
                else if (ext_id_next == EXT_VERSIONS) phase_next = PH_SV;
                else                                  phase_next = PH_SKIP;
              end
            end
            default: begin
              body_start = field_end_next - 17'(ext_len_next);
              r = 17'(pos) - body_start;
              if (phase_next == PH_SNI && ext_len_next >= 16'd5) begin
                if (r == 17'd3) inner_next = 16'(b);
                else if (r == 17'd4) begin
                  v16 = {inner_next[7:0], b};
                  inner_next = (17'd5 + 17'(v16) <= 17'(ext_len_next)) ? v16 : 16'd0;
                end else if (r >= 17'd5 && (r - 17'd5) < 17'(inner_next)) begin
                  name_vld = 1'b1;
                  res_name.kind = KIND_SNI;
                  res_name.name_byte = b;
                end
              end else if (phase_next == PH_ALPN && ext_len_next >= 16'd4) begin
                if (r == 17'd0) inner_next = 16'(b);
                else if (r == 17'd1) begin
                  v16 = {inner_next[7:0], b};
                  inner_next = (v16 >= 16'd2 && 17'(v16) + 17'd2 <= 17'(ext_len_next))
                               ? 16'd1 : 16'd0;
                end else if (r == 17'd2) begin
                  inner_next = (inner_next == 16'd1 && b != 8'd0 &&
                                17'(b) + 17'd3 <= 17'(ext_len_next)) ? 16'(b) : 16'd0;
                end else if ((r - 17'd3) < 17'(inner_next)) begin
                  name_vld = 1'b1;
                  res_name.kind = KIND_ALPN;
                  res_name.name_byte = b;
                end
              end else if (phase_next == PH_SV && ext_len_next >= 16'd3) begin
                // odd body offsets hold the high byte of a version pair
                if (r == 17'd0) inner_next = 16'(b);
                else if (r[0]) ext_id_next = 16'(b);
                else if (r <= 17'(inner_next) && {ext_id_next[7:0], b} == VER_TLS13)
                  tls13_next = 1'b1;
              end
              if (17'(pos) + 17'd1 == field_end_next) begin
                start = 18'(field_end_next);
                do_begin = 1'b1;
              end
            end
          endcase
          if (do_begin) begin
            if (start + 18'd4 > 18'(ext_end_next)) phase_next = PH_IDLE;
            else begin
              field_end_next = start[16:0];
              phase_next = PH_ET0;
            end
          end
        end
      end

      offset_next = (pos < 16'hFFFF) ? pos + 16'd1 : pos;

      if (s_tlast) begin
        res_sum.kind           = KIND_SUMMARY;
        res_sum.run_end        = 1'b1;
        res_sum.handshake_kind = ABSENT;
        res_sum.alert_sev      = ABSENT;
        res_sum.alert_reason   = ABSENT;
        if (rbytes_next >= 16'd5) begin
          res_sum.content_type  = hdr_next[0];
          res_sum.ver_major     = hdr_next[1];
          res_sum.ver_minor     = hdr_next[2];
          res_sum.record_length = {hdr_next[3], hdr_next[4]};
          if (hdr_next[0] == REC_HANDSHAKE && rbytes_next >= 16'd6)
            res_sum.handshake_kind = 9'(hdr_next[5]);
          if (hdr_next[0] == REC_ALERT && rbytes_next >= 16'd7) begin
            res_sum.alert_sev    = 9'(hdr_next[5]);
            res_sum.alert_reason = 9'(hdr_next[6]);
          end
          if (hdr_next[1] == 8'd3 && hdr_next[2] >= 8'd1 && hdr_next[2] <= 8'd4)
            label = hdr_next[2][2:0];
          if (tls13_next) label = 3'd4;
          res_sum.version_label = label;
          res_sum.header_valid  = 1'b1;
        end
        offset_next    = '0;
        rbytes_next    = '0;
        phase_next     = PH_HEAD;
        field_end_next = '0;
        ext_end_next   = '0;
        ext_id_next    = '0;
        ext_len_next   = '0;
        inner_next     = '0;
        tls13_next     = 1'b0;
        for (int i = 0; i < 7; i++) hdr_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      rbytes    <= '0;
      phase     <= PH_HEAD;
      field_end <= '0;
      ext_end   <= '0;
      ext_id    <= '0;
      ext_len   <= '0;
      inner     <= '0;
      tls13     <= 1'b0;
      for (int i = 0; i < 7; i++) hdr[i] <= '0;
    end else begin
      offset    <= offset_next;
      rbytes    <= rbytes_next;
      phase     <= phase_next;
      field_end <= field_end_next;
      ext_end   <= ext_end_next;
      ext_id    <= ext_id_next;
      ext_len   <= ext_len_next;
      inner     <= inner_next;
      tls13     <= tls13_next;
      for (int i = 0; i < 7; i++) hdr[i] <= hdr_next[i];
    end
  end

  // output queue: up to two words pushed per accepted byte
  result_t     q [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;
  logic        push0, push1, pop;
  logic [1:0]  w1;
  result_t     head;

  assign push0 = accept && name_vld;
  assign push1 = accept && s_tlast;
  assign pop   = m_tvalid && m_tready;
  assign w1    = push0 ? wptr + 2'd1 : wptr;
  assign s_tready = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push0) q[wptr] <= res_name;
    if (push1) q[w1]   <= res_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + 2'(push0) + 2'(push1);
      rptr  <= rptr + 2'(pop);
      count <= count + 3'(push0) + 3'(push1) - 3'(pop);
    end
  end

  assign head     = q[rptr];
  assign m_tvalid = (count != 3'd0);
  assign m_tuser  = head.kind;
  assign m_tlast  = head.run_end;
  assign m_tdata  = {1'b0, head.header_valid, head.version_label, head.alert_reason,
                     head.alert_sev, head.handshake_kind, head.record_length,
                     head.ver_minor, head.ver_major, head.content_type,
                     head.name_byte};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4) else $error("output queue overflow");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    count > 3'd2 |-> !s_tready) else $error("accept with queue nearly full");

  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_SUMMARY) else $error("run end on name word");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3) else $error("bad result kind");

  a_summary_resets: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == PH_HEAD && offset == 16'd0)
    else $error("state not cleared after summary");

endmodule
`default_nettype wire

// File: dv/tb_tls_client_hello_sni_alpn_parser.sv
`timescale 1ns / 1ps
module tb_tls_client_hello_sni_alpn_parser;
  import tls_sni_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // data_byte[7:0], total_length[23:8]
  logic        s_tuser = 1'b0; // first_byte
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // name_byte, content type, major, minor, record_length,
                               // handshake_kind, alert level, alert_reason,
                               // version_label, header_valid, pad
  logic [1:0]  m_tuser;        // result_kind
  logic        m_tlast;        // run_end

  tls_client_hello_sni_alpn_parser uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [7:0]  d;
    bit          fb, lb;
    logic [15:0] tl;
    bit          typed;
    result_t     res;
  } stim_row_t;

  int unsigned cyc = 0;
  int          errors = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int unsigned hold_left = 0;
  int          stall_mode = 0;
  result_t     pending_results[$];
  stim_row_t   rows[$];

  function automatic void queue_word(result_t x);
    pending_results.insert(pending_results.size(), x);
  endfunction

  function automatic void put_b(ref logic [7:0] q[$], input int unsigned v);
    q.insert(q.size(), v[7:0]);
  endfunction

  function automatic void add_row(logic [7:0] d, bit fb, bit lb, logic [15:0] tl,
                                  bit typed, result_t res);
    stim_row_t w;
    w.d = d; w.fb = fb; w.lb = lb; w.tl = tl; w.typed = typed; w.res = res;
    rows.insert(rows.size(), w);
  endfunction

  // ---------------- parser model ----------------
  int unsigned off, rec_len, fend, xend, xtype, xlen, ilen;
  phase_t      ph;
  logic [7:0]  hb[7];
  bit          saw13;
  result_t     pout[2];
  int          pn;

  function automatic void clear_rec();
    off = 0; rec_len = 0; ph = PH_HEAD; fend = 0; xend = 0; xtype = 0;
    xlen = 0; ilen = 0; saw13 = 0;
    for (int i = 0; i < 7; i++) hb[i] = 8'h00;
  endfunction

  function automatic void next_ext(int unsigned st);
    if (st + 4 > xend) ph = PH_IDLE;
    else begin
      fend = st;
      ph = PH_ET0;
    end
  endfunction

  function automatic void emit_name(logic [1:0] kind, logic [7:0] b);
    pout[pn] = '0;
    pout[pn].kind = kind;
    pout[pn].name_byte = b;
    pn++;
  endfunction

  function automatic void parse_byte(int unsigned pos, int unsigned b);
    int unsigned nxt, r, l;
    if (ph == PH_IDLE) return;
    if (ph == PH_HEAD) begin
      if (pos != 5) return;
      if (hb[0] == REC_HANDSHAKE && b == HS_CLIENT_HELLO && rec_len > HELLO_MIN) begin
        ph = PH_SID;
        fend = HELLO_MIN;
      end else ph = PH_IDLE;
      return;
    end
    if (ph <= PH_EL1 && pos != fend) return;
    case (ph)
      PH_SID: begin
        nxt = pos + 1 + b;
        if (nxt + 2 > rec_len) ph = PH_IDLE;
        else begin fend = nxt; ph = PH_CSHI; end
      end
      PH_CSHI, PH_EXHI: begin
        ilen = b; fend = pos + 1;
        ph = (ph == PH_CSHI) ? PH_CSLO : PH_EXLO;
      end
      PH_CSLO: begin
        nxt = pos + 1 + ((ilen << 8) | b);
        if (nxt >= rec_len) ph = PH_IDLE;
        else begin fend = nxt; ph = PH_COMP; end
      end
      PH_COMP: begin
        nxt = pos + 1 + b;
        if (nxt + 2 > rec_len) ph = PH_IDLE;
        else begin fend = nxt; ph = PH_EXHI; end
      end
      PH_EXLO: begin
        nxt = pos + 1 + ((ilen << 8) | b);
        xend = (nxt > rec_len) ? rec_len : nxt;
        next_ext(pos + 1);
      end
      PH_ET0: begin xtype = b << 8; fend = pos + 1; ph = PH_ET1; end
      PH_ET1: begin xtype |= b; fend = pos + 1; ph = PH_EL0; end
      PH_EL0: begin xlen = b << 8; fend = pos + 1; ph = PH_EL1; end
      PH_EL1: begin
        xlen |= b;
        nxt = pos + 1;
        ilen = 0;
        if (nxt + xlen > xend) ph = PH_IDLE;
        else if (xlen == 0) next_ext(nxt);
        else begin
          fend = nxt + xlen;
          if (xtype == EXT_SNI) ph = PH_SNI;
          else if (xtype == EXT_ALPN) ph = PH_ALPN;
          else if (xtype == EXT_VERSIONS) ph = PH_SV;
          else ph = PH_SKIP;
        end
      end
      default: begin
        l = xlen;
        r = pos - (fend - l);
        if (ph == PH_SNI && l >= 5) begin
          if (r == 3) ilen = b;
          else if (r == 4) begin
            nxt = (ilen << 8) | b;
            ilen = (5 + nxt <= l) ? nxt : 0;
          end else if (r >= 5 && r - 5 < ilen) emit_name(KIND_SNI, b[7:0]);
        end else if (ph == PH_ALPN && l >= 4) begin
          if (r == 0) ilen = b;
          else if (r == 1) begin
            nxt = (ilen << 8) | b;
            ilen = (nxt >= 2 && nxt + 2 <= l) ? 1 : 0;
          end else if (r == 2) begin
            ilen = (ilen == 1 && b != 0 && b + 3 <= l) ? b : 0;
          end else if (r - 3 < ilen) emit_name(KIND_ALPN, b[7:0]);
        end else if (ph == PH_SV && l >= 3) begin
          if (r == 0) ilen = b;
          else if (r[0]) xtype = b;
          else if (r <= ilen && ((xtype << 8) | b) == VER_TLS13) saw13 = 1;
        end
        if (pos + 1 == fend) next_ext(fend);
      end
    endcase
  endfunction

  function automatic void emit_summary();
    result_t s = '0;
    s.kind = KIND_SUMMARY;
    s.handshake_kind = ABSENT;
    s.alert_sev = ABSENT;
    s.alert_reason = ABSENT;
    s.run_end = 1'b1;
    if (rec_len >= 5) begin
      s.content_type = hb[0];
      s.ver_major = hb[1];
      s.ver_minor = hb[2];
      s.record_length = {hb[3], hb[4]};
      if (hb[0] == REC_HANDSHAKE && rec_len >= 6) s.handshake_kind = {1'b0, hb[5]};
      if (hb[0] == REC_ALERT && rec_len >= 7) begin
        s.alert_sev = {1'b0, hb[5]};
        s.alert_reason = {1'b0, hb[6]};
      end
      if (hb[1] == 8'd3 && hb[2] >= 8'd1 && hb[2] <= 8'd4) s.version_label = hb[2][2:0];
      if (saw13) s.version_label = 3'd4;
      s.header_valid = 1'b1;
    end
    pout[pn] = s;
    pn++;
  endfunction

  function automatic void sni_predict(logic [7:0] d, bit fb, bit lb, logic [15:0] tl);
    int unsigned pos;
    pn = 0;
    if (fb) begin
      clear_rec();
      rec_len = tl;
    end
    pos = off;
    if (pos < rec_len) begin
      if (pos < 7) hb[pos] = d;
      parse_byte(pos, d);
    end
    if (off < 65535) off++;
    if (lb) begin
      emit_summary();
      clear_rec();
    end
  endfunction

  // ---------------- driver ----------------
  task automatic send_byte(logic [7:0] d, bit fb, bit lb, logic [15:0] tl,
                           bit typed = 0, result_t tres = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {tl, d};
    s_tuser <= fb;
    s_tlast <= lb;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    sni_predict(d, fb, lb, tl);
    if (typed) queue_word(tres);
    else for (int i = 0; i < pn; i++) queue_word(pout[i]);
  endtask

  task automatic send_record(ref logic [7:0] q[$], input logic [15:0] tl, input int last_at);
    for (int i = 0; i < q.size() && i <= last_at; i++)
      send_byte(q[i], i == 0, i == last_at, tl);
  endtask

  task automatic build_hello(ref logic [7:0] q[$]);
    int n, k, ell, l;
    q = {};
    put_b(q, REC_HANDSHAKE); put_b(q, 8'h03); put_b(q, $urandom_range(0, 5));
    put_b(q, 0); put_b(q, 0);
    put_b(q, HS_CLIENT_HELLO); put_b(q, 0); put_b(q, 0); put_b(q, 0);
    put_b(q, 8'h03); put_b(q, 8'h03);
    repeat (32) put_b(q, $urandom);
    n = $urandom_range(0, 8);
    put_b(q, n);
    repeat (n) put_b(q, $urandom);
    k = $urandom_range(1, 3);
    put_b(q, 0); put_b(q, 2 * k);
    repeat (2 * k) put_b(q, $urandom);
    put_b(q, 1); put_b(q, 0);
    ell = q.size();
    put_b(q, 0); put_b(q, 0);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(0, 12);
          l = 5 + n;
          put_b(q, EXT_SNI[15:8]); put_b(q, EXT_SNI[7:0]);
          put_b(q, l >> 8); put_b(q, l); put_b(q, (l - 2) >> 8);
          put_b(q, l - 2); put_b(q, 0); put_b(q, n >> 8); put_b(q, n);
          repeat (n) put_b(q, $urandom_range(0, 1) ? $urandom_range(97, 122) : $urandom);
        end
        1: begin
          n = $urandom_range(1, 10);
          put_b(q, EXT_ALPN[15:8]); put_b(q, EXT_ALPN[7:0]);
          put_b(q, 0); put_b(q, 3 + n); put_b(q, 0); put_b(q, 1 + n);
          put_b(q, n);
          repeat (n) put_b(q, $urandom_range(97, 122));
        end
        2: begin
          k = $urandom_range(1, 4);
          put_b(q, EXT_VERSIONS[15:8]); put_b(q, EXT_VERSIONS[7:0]);
          put_b(q, 0); put_b(q, 1 + 2 * k); put_b(q, 2 * k);
          repeat (k) begin
            put_b(q, 8'h03);
            put_b(q, $urandom_range(0, 2) == 0 ? 8'h04 : $urandom_range(0, 3));
          end
        end
        default: begin
          n = $urandom_range(0, 6);
          put_b(q, $urandom); put_b(q, $urandom); put_b(q, 0); put_b(q, n);
          repeat (n) put_b(q, $urandom);
        end
      endcase
    end
    l = q.size() - ell - 2;
    q[ell] = 8'(l >> 8); q[ell + 1] = 8'(l);
    l = q.size() - 5;
    q[3] = 8'(l >> 8); q[4] = 8'(l);
    l = q.size() - 9;
    q[7] = 8'(l >> 8); q[8] = 8'(l);
    // occasional corruption to exercise the length checks
    if ($urandom_range(0, 3) == 0) q[$urandom_range(5, q.size() - 1)] = 8'($urandom);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("tls_client_hello_sni_alpn_parser regression: fail");
      $finish;
    end
  end

  // long hold-off so the output queue fills and s_tready drops
  always @(posedge clk) begin
    if (cyc == 300) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (cyc[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    if (rst || hold_left != 0) m_tready <= 1'b0;
    else case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.name_byte = m_tdata[7:0];
      got.content_type = m_tdata[15:8];
      got.ver_major = m_tdata[23:16];
      got.ver_minor = m_tdata[31:24];
      got.record_length = m_tdata[47:32];
      got.handshake_kind = m_tdata[56:48];
      got.alert_sev = m_tdata[65:57];
      got.alert_reason = m_tdata[74:66];
      got.version_label = m_tdata[77:75];
      got.header_valid = m_tdata[78];
      got.run_end = m_tlast;
      if (pending_results.size() == 0) report("unexpected word, kind", got.kind, -1);
      else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) report("result_kind", got.kind, want.kind);
        if (got.name_byte != want.name_byte) report("name_byte", got.name_byte, want.name_byte);
        if (got.content_type != want.content_type)
          report("content type", got.content_type, want.content_type);
        if (got.ver_major != want.ver_major)
          report("major version", got.ver_major, want.ver_major);
        if (got.ver_minor != want.ver_minor)
          report("minor version", got.ver_minor, want.ver_minor);
        if (got.record_length != want.record_length)
          report("record_length", got.record_length, want.record_length);
        if (got.handshake_kind != want.handshake_kind)
          report("handshake_kind", got.handshake_kind, want.handshake_kind);
        if (got.alert_sev != want.alert_sev)
          report("alert level", got.alert_sev, want.alert_sev);
        if (got.alert_reason != want.alert_reason)
          report("alert_reason", got.alert_reason, want.alert_reason);
        if (got.version_label != want.version_label)
          report("version_label", got.version_label, want.version_label);
        if (got.header_valid != want.header_valid)
          report("header_valid", got.header_valid, want.header_valid);
        if (got.run_end != want.run_end) report("run_end", got.run_end, want.run_end);
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    result_t     absent, r;
    logic [7:0]  q[$];
    int          lat;
    logic [15:0] tl;

    absent = '0;
    absent.kind = KIND_SUMMARY;
    absent.handshake_kind = ABSENT;
    absent.alert_sev = ABSENT;
    absent.alert_reason = ABSENT;
    absent.run_end = 1'b1;

    // stray last byte with no record open
    add_row(8'hFF, 0, 1, 16'hFFFF, 1, absent);
    // record shorter than a header
    add_row(8'h16, 1, 0, 16'd3, 0, '0);
    add_row(8'h03, 0, 0, 16'd3, 0, '0);
    add_row(8'h01, 0, 1, 16'd3, 1, absent);
    // alert record
    r = absent; r.content_type = REC_ALERT; r.ver_major = 3; r.ver_minor = 3;
    r.record_length = 2; r.alert_sev = 9'd2; r.alert_reason = 9'h28;
    r.version_label = 3; r.header_valid = 1;
    add_row(REC_ALERT, 1, 0, 16'd7, 0, '0);
    add_row(8'h03, 0, 0, 16'd7, 0, '0);
    add_row(8'h03, 0, 0, 16'd7, 0, '0);
    add_row(8'h00, 0, 0, 16'd7, 0, '0);
    add_row(8'h02, 0, 0, 16'd7, 0, '0);
    add_row(8'h02, 0, 0, 16'd7, 0, '0);
    add_row(8'h28, 0, 1, 16'd7, 1, r);
    // dropped record, then a new first byte mid-record (no summary for the first)
    add_row(REC_HANDSHAKE, 1, 0, 16'd50, 0, '0);
    add_row(8'h03, 0, 0, 16'd50, 0, '0);
    r = absent; r.content_type = REC_ALERT; r.ver_major = 3; r.ver_minor = 4;
    r.version_label = 4; r.header_valid = 1;
    add_row(REC_ALERT, 1, 0, 16'd5, 0, '0);
    add_row(8'h03, 0, 0, 16'd5, 0, '0);
    add_row(8'h04, 0, 0, 16'd5, 0, '0);
    add_row(8'h00, 0, 0, 16'd5, 0, '0);
    add_row(8'h00, 0, 1, 16'd5, 1, r);
    // zero length: everything ignored
    add_row(8'h00, 1, 1, 16'd0, 1, absent);
    // full length, one byte then early last
    r = absent; r.content_type = 8'hFF; r.header_valid = 1;
    add_row(8'hFF, 1, 1, 16'hFFFF, 1, r);
    // handshake that is not a ClientHello, checked by the model
    add_row(REC_HANDSHAKE, 1, 0, 16'd6, 0, '0);
    add_row(8'h03, 0, 0, 16'd6, 0, '0);
    add_row(8'h01, 0, 0, 16'd6, 0, '0);
    add_row(8'h00, 0, 0, 16'd6, 0, '0);
    add_row(8'h01, 0, 0, 16'd6, 0, '0);
    add_row(8'h02, 0, 1, 16'd6, 0, '0);

    clear_rec();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_byte(rows[i].d, rows[i].fb, rows[i].lb, rows[i].tl,
                                rows[i].typed, rows[i].res);

    while (words_sent < 1750) begin
      case ($urandom_range(0, 9))
        0: begin // noise record, any length value
          q = {};
          repeat ($urandom_range(1, 20)) put_b(q, $urandom);
          send_record(q, 16'($urandom), $urandom_range(0, 1) ? q.size() - 1 : q.size());
        end
        1: send_byte(8'($urandom), 0, $urandom_range(0, 1), 16'($urandom)); // stray word
        default: begin
          build_hello(q);
          tl = 16'(q.size());
          if ($urandom_range(0, 7) == 0) tl = 16'($urandom_range(0, q.size()));
          lat = q.size() - 1;
          case ($urandom_range(0, 19))
            0, 1: lat = $urandom_range(0, q.size() - 1);
            2: lat = q.size(); // no last byte: next record starts mid-run
            default: ;
          endcase
          send_record(q, tl, lat);
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tls_client_hello_sni_alpn_parser regression: pass");
    else $display("tls_client_hello_sni_alpn_parser regression: fail");
    $finish;
  end

endmodule
